// ----- hw/rtl/bcpr_pkg.sv -----
// Shared types and constants for the Pascal-row binomial coefficient unit.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package bcpr_pkg;

	localparam int CNT_W  = 6;
	localparam int COEF_W = 60;

	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [COEF_W-1:0] coef_t;

	localparam coef_t COEF_MAX = '1;
	localparam coef_t COEF_ONE = coef_t'(1);

endpackage

// ----- hw/rtl/bcpr_req_if.sv -----
// Request channel: valid/ready plus the n, k pair.
// Depends on bcpr_pkg.
`timescale 1ns / 1ps

interface bcpr_req_if;
	logic              valid;
	logic              ready;
	bcpr_pkg::cnt_t    count_n;
	bcpr_pkg::cnt_t    choose_k;

	modport source (output valid, output count_n, output choose_k, input ready);
	modport sink   (input valid, input count_n, input choose_k, output ready);
endinterface

// ----- hw/rtl/bcpr_rsp_if.sv -----
// Response channel: valid/ready plus the 60-bit coefficient.
// Depends on bcpr_pkg.
`timescale 1ns / 1ps

interface bcpr_rsp_if;
	logic              valid;
	logic              ready;
	bcpr_pkg::coef_t   coefficient;

	modport source (output valid, output coefficient, input ready);
	modport sink   (input valid, input coefficient, output ready);
endinterface

// ----- hw/rtl/bcpr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bcpr_ram #(
	parameter int WIDTH = 60,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/bcpr_sat_add.sv -----
// Shared 60-bit adder that saturates at the all-ones coefficient.
// Depends on bcpr_pkg.
`timescale 1ns / 1ps

module bcpr_sat_add (
	input  bcpr_pkg::coef_t a,
	input  bcpr_pkg::coef_t b,
	output bcpr_pkg::coef_t sum
);
	import bcpr_pkg::*;

	logic [COEF_W:0] wide;

	// carry out means the sum left the coefficient range
	assign wide = {1'b0, a} + {1'b0, b};
	assign sum  = wide[COEF_W] ? COEF_MAX : wide[COEF_W-1:0];

endmodule

// ----- hw/rtl/binomial_coefficient_pascal_row_unit.sv -----
// Top level: sequencer that builds one Pascal row in a RAM using a shared adder.
// Depends on bcpr_pkg, bcpr_req_if, bcpr_rsp_if, bcpr_ram, bcpr_sat_add.
//
//   channel | dir | payload                      | transfer when
//   --------+-----+------------------------------+---------------------
//   req     | in  | count_n[5:0], choose_k[5:0]  | req.valid & req.ready
//   rsp     | out | coefficient[59:0]            | rsp.valid & rsp.ready
//
// A request with k = 0, k > n or out of range goes straight to S_DONE; any other
// walks rows 1..n (S_ROW, S_PRIME, S_UPD per column min(i,k)..1), S_FIN, S_FWAIT.
// One row-store update per cycle, bounded by the RAM's single read port.
// req.ready is high only when idle; a finished result waits in the output
// register and the next request is taken meanwhile. A result still stalled
// when the next one is ready holds the sequencer in its last state.
// Reset clears the sequencer and rsp.valid; the row store needs no clearing.
`timescale 1ns / 1ps

module binomial_coefficient_pascal_row_unit #(
	parameter int K_MAX = 63,
	parameter int N_MAX = 63
) (
	input  logic      clk,
	input  logic      arst_n,
	bcpr_req_if.sink  req,
	bcpr_rsp_if.source rsp
);
	import bcpr_pkg::*;

	localparam int AW = $clog2(K_MAX + 1);
	localparam logic [CNT_W:0] K_LIM = (CNT_W + 1)'(K_MAX);
	localparam logic [CNT_W:0] N_LIM = (CNT_W + 1)'(N_MAX);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROW,
		S_PRIME,
		S_UPD,
		S_FIN,
		S_FWAIT,
		S_DONE
	} state_t;

	state_t state_q;
	cnt_t   n_q, k_q;
	cnt_t   row_q;          // current row i
	cnt_t   col_q;          // column being written
	coef_t  hold_q;         // old value of the column being written
	coef_t  res_q;
	coef_t  out_data_q;
	logic   out_valid_q;
	logic   rd_one_q, rd_zero_q;

	cnt_t   top_w;
	cnt_t   rd_addr;
	logic   rd_one_d, rd_zero_d;
	coef_t  ram_rdata;
	coef_t  rval;
	coef_t  sum_w;
	logic   req_bad;

	// highest column touched in this row
	assign top_w = (row_q < k_q) ? row_q : k_q;

	// read address per state; entries not yet written this item read as zero
	always_comb begin
		rd_addr = '0;
		case (state_q)
			S_ROW:   rd_addr = top_w;
			S_PRIME: rd_addr = col_q - cnt_t'(1);
			S_UPD:   rd_addr = col_q - cnt_t'(2);
			S_FIN:   rd_addr = k_q;
			default: rd_addr = '0;
		endcase
		rd_one_d  = (rd_addr == '0);
		rd_zero_d = (state_q != S_FIN) && (rd_addr >= row_q);
	end

	assign rval = rd_one_q ? COEF_ONE : (rd_zero_q ? '0 : ram_rdata);

	// row store
	bcpr_ram #(
		.WIDTH (COEF_W),
		.DEPTH (K_MAX + 1)
	) u_row_ram (
		.clk   (clk),
		.we    (state_q == S_UPD),
		.waddr (col_q[AW-1:0]),
		.wdata (sum_w),
		.raddr (rd_addr[AW-1:0]),
		.rdata (ram_rdata)
	);

	// shared adder: old entry plus its left neighbour
	bcpr_sat_add u_add (
		.a   (hold_q),
		.b   (rval),
		.sum (sum_w)
	);

	assign req_bad = ({1'b0, req.choose_k} > K_LIM) || ({1'b0, req.count_n} > N_LIM)
		|| (req.choose_k > req.count_n);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
		end else begin
			rd_one_q  <= rd_one_d;
			rd_zero_q <= rd_zero_d;
			// S_DONE reloads the output register itself
			if (out_valid_q && rsp.ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						n_q <= req.count_n;
						k_q <= req.choose_k;
						if (req_bad) begin
							res_q   <= '0;
							state_q <= S_DONE;
						end else if (req.choose_k == '0) begin
							res_q   <= COEF_ONE;
							state_q <= S_DONE;
						end else begin
							row_q   <= cnt_t'(1);
							state_q <= S_ROW;
						end
					end
				end
				S_ROW: begin
					col_q   <= top_w;
					state_q <= S_PRIME;
				end
				S_PRIME: begin
					hold_q  <= rval;
					state_q <= S_UPD;
				end
				S_UPD: begin
					hold_q <= rval;
					if (col_q == cnt_t'(1)) begin
						if (row_q == n_q) begin
							state_q <= S_FIN;
						end else begin
							row_q   <= row_q + cnt_t'(1);
							state_q <= S_ROW;
						end
					end else begin
						col_q <= col_q - cnt_t'(1);
					end
				end
				S_FIN: begin
					state_q <= S_FWAIT;
				end
				S_FWAIT: begin
					res_q   <= rval;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= res_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.coefficient = out_data_q;

endmodule

// ----- hw/rtl/bcpr_check.sv -----
// Port-level checks for the Pascal-row binomial coefficient unit, bound to the top.
// Depends on bcpr_pkg and binomial_coefficient_pascal_row_unit.
`timescale 1ns / 1ps

module bcpr_check (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_ready,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input bcpr_pkg::coef_t rsp_coefficient
);
	import bcpr_pkg::*;

	// a stalled result stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp.valid dropped while stalled");

	// a stalled result keeps its value
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_coefficient))
		else $error("rsp.coefficient changed while stalled");

	// one request at a time: busy right after a request transfer
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("req.ready high right after a transfer");

	// a new result is only loaded while the unit is busy
	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("result appeared while idle");

endmodule

bind binomial_coefficient_pascal_row_unit bcpr_check u_bcpr_check (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_coefficient (rsp.coefficient)
);

// ----- dv/tb_top.sv -----
// Self-checking testbench for binomial_coefficient_pascal_row_unit: directed and random n, k
// requests, with random idles and stalls; a scoreboard class rebuilds the Pascal row to predict.
// Depends on bcpr_pkg, bcpr_req_if, bcpr_rsp_if and the RTL of the unit.
`timescale 1ns / 1ps

module tb_top;
	import bcpr_pkg::*;

	localparam int K_MAX        = 63;
	localparam int N_MAX        = 63;
	localparam int RANDOM_ITEMS = 270;
	localparam int MAX_IDLE     = 10;
	// drain covers one more full item, the longest included
	localparam int DRAIN_CYCLES = 2200;
	// slowest run: ~290 items, each the longest plus both idles, taken about six times over
	localparam int CYCLE_LIMIT  = 4_000_000;
	localparam int REPORT_MAX   = 10;

	// One outstanding request and the coefficient it must produce
	typedef struct {
		cnt_t  n;
		cnt_t  k;
		coef_t coef;
	} coef_entry_t;

	// Predicts C(n,k) by building one Pascal row, and checks transfers in order
	class coef_scoreboard;
		coef_t       row[K_MAX+1];
		coef_entry_t pending_coefs[$];
		int          mismatches;
		int          checked;
		int          requests;
		int          k_above_n;
		int          k_zero;
		int          n_full;

		function coef_t pascal_coef(cnt_t n, cnt_t k);
			logic [COEF_W:0] sum;
			int              top;
			// out-of-range requests are refused with zero, store untouched
			if (int'(k) > K_MAX || int'(n) > N_MAX)
				return '0;
			foreach (row[j])
				row[j] = '0;
			row[0] = COEF_ONE;
			for (int i = 1; i <= int'(n); i++) begin
				top = (i < int'(k)) ? i : int'(k);
				for (int j = top; j > 0; j--) begin
					sum    = {1'b0, row[j]} + {1'b0, row[j-1]};
					row[j] = sum[COEF_W] ? COEF_MAX : sum[COEF_W-1:0];
				end
			end
			return row[k];
		endfunction

		function void note_request(cnt_t n, cnt_t k);
			coef_entry_t e;
			e.n    = n;
			e.k    = k;
			e.coef = pascal_coef(n, k);
			pending_coefs.push_back(e);
			requests++;
			if (k > n)
				k_above_n++;
			if (k == 0)
				k_zero++;
			if (int'(n) == N_MAX)
				n_full++;
		endfunction

		function void check_result(coef_t got);
			coef_entry_t e;
			if (pending_coefs.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("ERROR: coefficient %0d arrived with no request outstanding", got);
				return;
			end
			e = pending_coefs.pop_front();
			checked++;
			if (got !== e.coef) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("ERROR: C(%0d,%0d) expected %0d, got %0d", e.n, e.k, e.coef, got);
			end
		endfunction

		function void flag_leftovers();
			foreach (pending_coefs[i]) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("ERROR: no result for C(%0d,%0d)",
						pending_coefs[i].n, pending_coefs[i].k);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   quiet;
	int   cycle_count;

	coef_scoreboard sb = new();

	bcpr_req_if req_ch();
	bcpr_rsp_if rsp_ch();

	binomial_coefficient_pascal_row_unit #(
		.K_MAX(K_MAX),
		.N_MAX(N_MAX)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ERROR: timeout after %0d cycles, %0d results outstanding",
				cycle_count, sb.pending_coefs.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// Sample both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				sb.note_request(req_ch.count_n, req_ch.choose_k);
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_result(rsp_ch.coefficient);
		end
	end

	function automatic int idle_cycles();
		return quiet ? 0 : $urandom_range(0, MAX_IDLE);
	endfunction

	// Present one request after a random idle and hold it until the transfer
	task automatic send_pair(cnt_t n, cnt_t k);
		int gap;
		gap = idle_cycles();
		repeat (gap) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
		@(negedge clk);
		req_ch.valid    <= 1'b1;
		req_ch.count_n  <= n;
		req_ch.choose_k <= k;
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	// Random request: mostly full range, with small, k > n and large-n shapes mixed in
	task automatic send_random();
		int shape;
		int n_val;
		int k_val;
		shape = $urandom_range(0, 99);
		if (shape < 55) begin
			n_val = $urandom_range(0, 63);
			k_val = $urandom_range(0, 63);
		end else if (shape < 80) begin
			n_val = $urandom_range(0, 15);
			k_val = $urandom_range(0, 15);
		end else if (shape < 92) begin
			n_val = $urandom_range(0, 62);
			k_val = $urandom_range(n_val + 1, 63);
		end else begin
			n_val = $urandom_range(56, 63);
			k_val = $urandom_range(20, 43);
		end
		send_pair(cnt_t'(n_val), cnt_t'(k_val));
	endtask

	// Response side: random stall before each transfer
	initial begin
		int stall;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = idle_cycles();
			repeat (stall) begin
				@(negedge clk);
				rsp_ch.ready <= 1'b0;
			end
			@(negedge clk);
			rsp_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!rsp_ch.valid);
		end
	end

	// Stimulus and end of run
	initial begin
		// extremes, k = 0, n = 0, k > n, symmetric pairs and the peak coefficient
		int dir_n[20] = '{0, 0, 0, 63, 63, 63, 63, 63, 1, 1, 5, 62, 1, 63, 10, 42, 21, 7, 2, 60};
		int dir_k[20] = '{0, 1, 63, 0, 63, 62, 31, 32, 1, 0, 6, 63, 63, 1, 5, 21, 42, 7, 1, 30};
		arst_n          = 1'b0;
		quiet           = 1'b0;
		cycle_count     = 0;
		req_ch.valid    = 1'b0;
		req_ch.count_n  = '0;
		req_ch.choose_k = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_n[i])
			send_pair(cnt_t'(dir_n[i]), cnt_t'(dir_k[i]));

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// switch between idling and back-to-back stretches
			if (i % 40 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			send_random();
		end
		@(negedge clk);
		req_ch.valid <= 1'b0;
		quiet = 1'b0;

		while (sb.pending_coefs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.flag_leftovers();

		$display("Ran %0d requests (%0d with k > n, %0d with k = 0, %0d with n = 63).",
			sb.requests, sb.k_above_n, sb.k_zero, sb.n_full);
		$display("Checked %0d coefficients, %0d mismatches, in %0d cycles.",
			sb.checked, sb.mismatches, cycle_count);
		if (sb.mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- binomial_coefficient_pascal_row_unit.f -----
hw/rtl/bcpr_pkg.sv
hw/rtl/bcpr_req_if.sv
hw/rtl/bcpr_rsp_if.sv
hw/rtl/bcpr_ram.sv
hw/rtl/bcpr_sat_add.sv
hw/rtl/binomial_coefficient_pascal_row_unit.sv
hw/rtl/bcpr_check.sv
dv/tb_top.sv
